FILE: rtl/aes_pkg.sv
`timescale 1ns / 1ps
package aes_pkg;

   localparam int NumRounds = 10;
   localparam int BlockWidth = 128;
   localparam int HalfWidth = 64;
   localparam int CsrIndexWidth = 1;
   localparam logic [CsrIndexWidth-1:0] CsrKeyHigh = 1'b0;
   localparam logic [CsrIndexWidth-1:0] CsrKeyLow = 1'b1;

   typedef logic [7:0] byte_type;
   typedef logic [BlockWidth-1:0] block_type;

   typedef struct packed {
      logic valid;
      logic last;
   } cell_ctl_type;

   localparam byte_type [0:255] SboxTable = {
      8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
      8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
      8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
      8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
      8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
      8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
      8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
      8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
      8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
      8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
      8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
      8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
      8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
      8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
      8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
      8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
      8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
      8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
      8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
      8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
      8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
      8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
      8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
      8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
      8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
      8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
      8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
      8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
      8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
      8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
      8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
      8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
   };

   function automatic byte_type sbox(input byte_type x);
      return SboxTable[x];
   endfunction

   function automatic byte_type xtime(input byte_type x);
      return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
   endfunction

   // Byte i of the block sits at bits [127-8i -: 8].
   function automatic byte_type get_byte(input block_type b, input int i);
      return b[BlockWidth-1-8*i -: 8];
   endfunction

endpackage

FILE: rtl/aes_round_cell.sv
`timescale 1ns / 1ps
module aes_round_cell
   import aes_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         advance,
   input  cell_ctl_type ctl_in,
   input  block_type    state_in,
   input  block_type    key_in,
   input  byte_type     rcon_in,
   output cell_ctl_type ctl_out,
   output block_type    state_out,
   output block_type    key_out,
   output byte_type     rcon_out
);

   cell_ctl_type ctl_ff;
   block_type    state_ff, state_in_nx;
   block_type    key_ff, key_in_nx;
   byte_type     rcon_ff;
   byte_type     t [0:15];
   byte_type     m [0:15];
   byte_type     w [0:15];
   byte_type     k [0:15];

   always_comb begin
      byte_type a0, a1, a2, a3, all;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            t[r + 4*c] = sbox(get_byte(state_in, r + 4*((c + r) & 3)));
         end
      end
      for (int c = 0; c < 4; c++) begin
         a0 = t[4*c];
         a1 = t[4*c+1];
         a2 = t[4*c+2];
         a3 = t[4*c+3];
         all = a0 ^ a1 ^ a2 ^ a3;
         m[4*c]   = a0 ^ all ^ xtime(a0 ^ a1);
         m[4*c+1] = a1 ^ all ^ xtime(a1 ^ a2);
         m[4*c+2] = a2 ^ all ^ xtime(a2 ^ a3);
         m[4*c+3] = a3 ^ all ^ xtime(a3 ^ a0);
      end
      for (int i = 0; i < 16; i++) begin
         w[i] = get_byte(key_in, i);
      end
      k[0] = w[0] ^ sbox(w[13]) ^ rcon_in;
      k[1] = w[1] ^ sbox(w[14]);
      k[2] = w[2] ^ sbox(w[15]);
      k[3] = w[3] ^ sbox(w[12]);
      for (int i = 4; i < 16; i++) begin
         k[i] = w[i] ^ k[i-4];
      end
      for (int i = 0; i < 16; i++) begin
         key_in_nx[BlockWidth-1-8*i -: 8] = k[i];
         state_in_nx[BlockWidth-1-8*i -: 8] = (ctl_in.last ? t[i] : m[i]) ^ k[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (advance) begin
         ctl_ff <= ctl_in;
      end
      if (advance) begin
         state_ff <= state_in_nx;
         key_ff <= key_in_nx;
         rcon_ff <= xtime(rcon_in);
      end
   end

   assign ctl_out = ctl_ff;
   assign state_out = state_ff;
   assign key_out = key_ff;
   assign rcon_out = rcon_ff;

endmodule

FILE: rtl/aes128_block_encrypt_top.sv
`timescale 1ns / 1ps
// AES-128 encryption engine. The key is written through the csr_ port:
// index 0 holds key bytes 0 to 7 and index 1 key bytes 8 to 15, byte 0 in
// the top bits. Write the key only while no request is in flight.
// A request on req_ carries one plaintext block and gives one ciphertext
// block on rsp_, with the same byte order.
// The datapath is a chain of ten round cells; each cell computes one round
// and the matching round key and hands both to the next cell every cycle
// that the chain advances. A request passes the input key add register and
// then the ten rounds; one request is taken every cycle the chain advances.
// When the receiver stalls, the whole chain holds and req_tready falls
// only while the last cell has a result that is not taken.
// Reset clears the key to zero and empties the chain.
module aes128_block_encrypt_top
   import aes_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [HalfWidth-1:0]     csr_wdata,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // block_high [63:0], block_low [127:64]
   input  logic [BlockWidth-1:0]    req_tdata,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // cipher_high [63:0], cipher_low [127:64]
   output logic [BlockWidth-1:0]    rsp_tdata
);

   logic [HalfWidth-1:0] key_high_ff, key_low_ff;
   logic                 advance;
   cell_ctl_type         ctl    [0:NumRounds];
   block_type            state  [0:NumRounds];
   block_type            rkey   [0:NumRounds];
   byte_type             rcon   [0:NumRounds];
   cell_ctl_type         ctl0_ff;
   block_type            state0_ff, key0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CsrKeyHigh: key_high_ff <= csr_wdata;
            CsrKeyLow:  key_low_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign advance = !ctl[NumRounds].valid || rsp_tready;
   assign req_tready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl0_ff <= '0;
      end else if (advance) begin
         ctl0_ff <= '{valid: req_tvalid, last: 1'b0};
      end
      if (advance) begin
         state0_ff <= {req_tdata[HalfWidth-1:0], req_tdata[HalfWidth +: HalfWidth]}
                      ^ {key_high_ff, key_low_ff};
         key0_ff <= {key_high_ff, key_low_ff};
      end
   end

   assign ctl[0] = ctl0_ff;
   assign state[0] = state0_ff;
   assign rkey[0] = key0_ff;
   assign rcon[0] = 8'h01;

   for (genvar g = 0; g < NumRounds; g++) begin : g_round
      cell_ctl_type c_in;
      always_comb begin
         c_in = ctl[g];
         c_in.last = (g == NumRounds - 1);
      end
      aes_round_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .ctl_in    (c_in),
         .state_in  (state[g]),
         .key_in    (rkey[g]),
         .rcon_in   (rcon[g]),
         .ctl_out   (ctl[g+1]),
         .state_out (state[g+1]),
         .key_out   (rkey[g+1]),
         .rcon_out  (rcon[g+1])
      );
   end

   assign rsp_tvalid = ctl[NumRounds].valid;
   assign rsp_tdata = {state[NumRounds][HalfWidth-1:0],
                       state[NumRounds][HalfWidth +: HalfWidth]};

   property p_hold_when_stalled;
      @(posedge clock) disable iff (reset)
         rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata);
   endproperty
   assert property (p_hold_when_stalled) else $error("result changed while stalled");

   property p_ready_when_empty;
      @(posedge clock) disable iff (reset) !rsp_tvalid |-> req_tready;
   endproperty
   assert property (p_ready_when_empty) else $error("stall with empty output");

   property p_last_marked;
      @(posedge clock) disable iff (reset) ctl[NumRounds].last == ctl[NumRounds].valid
         || !ctl[NumRounds].valid;
   endproperty
   assert property (p_last_marked) else $error("final cell missing last mark");

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
module testbench;
   import aes_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CsrIndexWidth-1:0] csr_index = '0;
   logic [HalfWidth-1:0] csr_wdata = '0;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [BlockWidth-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [BlockWidth-1:0] rsp_tdata;

   aes128_block_encrypt_top uut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   logic [63:0] key_hi_model, key_lo_model;
   logic [127:0] cipher_queue[$];
   int errors = 0;
   int cycles = 0;
   int blocks_sent = 0;
   int blocks_checked = 0;
   bit rsp_hold_off = 1'b0;
   bit no_idle = 1'b0;

   function automatic logic [7:0] gmul2(input logic [7:0] x);
      return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] r;
      r = 8'h00;
      for (int k = 0; k < 8; k++) begin
         if (b[0]) r ^= a;
         a = gmul2(a);
         b = b >> 1;
      end
      return r;
   endfunction

   function automatic logic [7:0] subst(input logic [7:0] x);
      logic [7:0] r, base, y;
      r = 8'h01;
      base = x;
      for (int e = 254; e != 0; e = e >> 1) begin
         if (e & 1) r = gmul(r, base);
         base = gmul(base, base);
      end
      y = r ^ {r[6:0], r[7]} ^ {r[5:0], r[7:6]} ^ {r[4:0], r[7:5]} ^ {r[3:0], r[7:4]};
      return y ^ 8'h63;
   endfunction

   function automatic logic [127:0] encrypt_block(input logic [63:0] kh,
         input logic [63:0] kl, input logic [127:0] pt);
      logic [7:0] rk[176];
      logic [7:0] s[16];
      logic [7:0] t[16];
      logic [7:0] w[4];
      logic [7:0] rc, tmp, a0, a1, a2, a3, all;
      logic [127:0] k, res;
      k = {kh, kl};
      for (int i = 0; i < 16; i++) begin
         rk[i] = k[127-8*i -: 8];
         s[i] = pt[127-8*i -: 8];
      end
      rc = 8'h01;
      for (int n = 16; n < 176; n += 4) begin
         for (int a = 0; a < 4; a++) w[a] = rk[n-4+a];
         if ((n & 15) == 0) begin
            tmp = w[0]; w[0] = w[1]; w[1] = w[2]; w[2] = w[3]; w[3] = tmp;
            for (int a = 0; a < 4; a++) w[a] = subst(w[a]);
            w[0] ^= rc;
            rc = gmul2(rc);
         end
         for (int a = 0; a < 4; a++) rk[n+a] = rk[n-16+a] ^ w[a];
      end
      for (int i = 0; i < 16; i++) s[i] ^= rk[i];
      for (int rnd = 1; rnd <= 10; rnd++) begin
         for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
               t[r+4*c] = subst(s[r+4*((c+r)&3)]);
         s = t;
         if (rnd < 10) begin
            for (int c = 0; c < 4; c++) begin
               a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
               all = a0 ^ a1 ^ a2 ^ a3;
               s[4*c] = a0 ^ all ^ gmul2(a0 ^ a1);
               s[4*c+1] = a1 ^ all ^ gmul2(a1 ^ a2);
               s[4*c+2] = a2 ^ all ^ gmul2(a2 ^ a3);
               s[4*c+3] = a3 ^ all ^ gmul2(a3 ^ a0);
            end
         end
         for (int i = 0; i < 16; i++) s[i] ^= rk[16*rnd+i];
      end
      for (int i = 0; i < 16; i++) res[127-8*i -: 8] = s[i];
      return res;
   endfunction

   // Receiver: random stall bursts, none at the end.
   always @(posedge clock) begin
      static int stall_left = 0;
      cycles <= cycles + 1;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (cipher_queue.size() == 0) begin
               $error("unexpected response %h", rsp_tdata);
               errors++;
            end else begin
               logic [127:0] want;
               want = cipher_queue.pop_front();
               if (rsp_tdata[63:0] !== want[127:64]) begin
                  $error("cipher_high expected %h actual %h", want[127:64], rsp_tdata[63:0]);
                  errors++;
               end
               if (rsp_tdata[127:64] !== want[63:0]) begin
                  $error("cipher_low expected %h actual %h", want[63:0], rsp_tdata[127:64]);
                  errors++;
               end
               blocks_checked++;
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (!no_idle && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 14) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
      if (cycles > 400000) begin
         $display("aes128_block_encrypt_top: mismatch");
         $finish;
      end
   end

   task automatic send_block(input logic [127:0] pt, input bit use_known,
         input logic [127:0] known);
      int gap;
      if (!no_idle && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 14);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {pt[63:0], pt[127:64]};
      cipher_queue.push_back(use_known ? known
            : encrypt_block(key_hi_model, key_lo_model, pt));
      do @(posedge clock); while (!req_tready);
      blocks_sent++;
   endtask

   task automatic drain;
      req_tvalid <= 1'b0;
      while (cipher_queue.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_keys(input logic [63:0] hi, input logic [63:0] lo);
      csr_we <= 1'b1;
      csr_index <= CsrKeyHigh;
      csr_wdata <= hi;
      @(posedge clock);
      csr_index <= CsrKeyLow;
      csr_wdata <= lo;
      @(posedge clock);
      csr_we <= 1'b0;
      key_hi_model = hi;
      key_lo_model = lo;
   endtask

   typedef struct {
      logic [127:0] pt;
      bit known;
      logic [127:0] ct;
   } vector_row_type;

   vector_row_type vectors[8];

   initial begin
      key_hi_model = '0;
      key_lo_model = '0;
      vectors[0] = '{128'h0, 1, 128'h66e94bd4ef8a2c3b884cfa59ca342b2e};
      vectors[1] = '{{128{1'b1}}, 0, 128'h0};
      vectors[2] = '{128'h80000000000000000000000000000000, 0, 128'h0};
      vectors[3] = '{128'h1, 0, 128'h0};
      vectors[4] = '{128'h00112233445566778899aabbccddeeff, 0, 128'h0};
      vectors[5] = '{128'haaaaaaaaaaaaaaaa5555555555555555, 0, 128'h0};
      vectors[6] = '{128'h5555555555555555aaaaaaaaaaaaaaaa, 0, 128'h0};
      vectors[7] = '{128'h0123456789abcdeffedcba9876543210, 0, 128'h0};
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (vectors[i]) send_block(vectors[i].pt, vectors[i].known, vectors[i].ct);
      drain();
      write_keys(64'h0001020304050607, 64'h08090a0b0c0d0e0f);
      send_block(128'h00112233445566778899aabbccddeeff, 1,
            128'h69c4e0d86a7b0430d8cdb78070b4c55a);
      drain();
      write_keys({64{1'b1}}, {64{1'b1}});
      foreach (vectors[i]) send_block(vectors[i].pt, 0, 128'h0);
      drain();
      for (int phase = 0; phase < 7; phase++) begin
         write_keys({$urandom, $urandom}, {$urandom, $urandom});
         if (phase == 6) no_idle = 1'b1;
         for (int n = 0; n < 100; n++) begin
            send_block({$urandom, $urandom, $urandom, $urandom}, 0, 128'h0);
            if (phase == 2 && n == 50) drain();
         end
         drain();
      end
      $display("Sent %0d blocks under ten keys, including all-zero and all-one keys;",
            blocks_sent);
      $display("checked %0d ciphertexts with random stalls on both sides.", blocks_checked);
      if (errors == 0) begin
         $display("aes128_block_encrypt_top: match");
      end else begin
         $display("aes128_block_encrypt_top: mismatch");
      end
      $finish;
   end
endmodule
